// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/ushc_pkg.sv -----
// Shared types, constants and helper functions of the script histogram classifier.
package ushc_pkg;

  // Counter and field widths
  localparam int COUNT_BITS   = 32;
  localparam int CNT_W        = COUNT_BITS;
  localparam int NUM_SCRIPTS  = 10;
  localparam int IDX_W        = 4;
  localparam int SUM_W        = CNT_W + $clog2(NUM_SCRIPTS);
  localparam int THR_W        = 7;
  localparam int THR_PER_REG  = 5;
  localparam int THR_REG_W    = THR_W * THR_PER_REG;
  localparam int CP_W         = 21;
  localparam int OUT_W        = 32;
  localparam int VERDICT_W    = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_W        = THR_REG_W;
  localparam int PB_W         = CNT_W + THR_W;
  localparam int PS_W         = SUM_W + THR_W;

  // Verdict codes beyond the script indices
  localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN = 4'd10;
  localparam logic [VERDICT_W-1:0] VERDICT_NONE    = 4'd11;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_LAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN   = 2'd2;

  // Percent scale for share comparisons
  localparam logic [THR_W-1:0] PERCENT_FULL = 7'd100;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0] script_idx_t;

  // Script indices
  localparam script_idx_t SCR_JAPANESE   = 4'd0;
  localparam script_idx_t SCR_CHINESE    = 4'd1;
  localparam script_idx_t SCR_KOREAN     = 4'd2;
  localparam script_idx_t SCR_VIETNAMESE = 4'd3;
  localparam script_idx_t SCR_THAI       = 4'd4;
  localparam script_idx_t SCR_ARABIC     = 4'd5;
  localparam script_idx_t SCR_GREEK      = 4'd6;
  localparam script_idx_t SCR_HEBREW     = 4'd7;
  localparam script_idx_t SCR_ARMENIAN   = 4'd8;
  localparam script_idx_t SCR_CYRILLIC   = 4'd9;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic        hit;
    script_idx_t idx;
  } class_t;

  typedef struct packed {
    script_idx_t idx;
    count_t      cnt;
  } cand_t;

  function automatic logic in_rng(logic [CP_W-1:0] c, logic [CP_W-1:0] lo,
                                  logic [CP_W-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  // Map a code point to its script; ranges are tested in priority order
  function automatic class_t classify(logic [CP_W-1:0] c);
    class_t r;
    r.hit = 1'b1;
    r.idx = SCR_JAPANESE;
    if (c <= 21'h002FF) begin
      r.hit = 1'b0;
    end else if (in_rng(c, 21'h03040, 21'h030FF) || in_rng(c, 21'h031F0, 21'h031FF)) begin
      r.idx = SCR_JAPANESE;
    end else if (in_rng(c, 21'h04E00, 21'h09FFF) || in_rng(c, 21'h03100, 21'h0312F) ||
                 in_rng(c, 21'h031A0, 21'h031BF) || in_rng(c, 21'h02F00, 21'h02FDF)) begin
      r.idx = SCR_CHINESE;
    end else if (in_rng(c, 21'h01100, 21'h011FF) || in_rng(c, 21'h03130, 21'h0318F) ||
                 in_rng(c, 21'h0A960, 21'h0A97F) || in_rng(c, 21'h0AC00, 21'h0D7FF)) begin
      r.idx = SCR_KOREAN;
    end else if (in_rng(c, 21'h01E00, 21'h01EFF)) begin
      r.idx = SCR_VIETNAMESE;
    end else if (in_rng(c, 21'h00E00, 21'h00E7F)) begin
      r.idx = SCR_THAI;
    end else if (in_rng(c, 21'h00600, 21'h006FF) || in_rng(c, 21'h0FB50, 21'h0FDFF) ||
                 in_rng(c, 21'h0FE70, 21'h0FEFF)) begin
      r.idx = SCR_ARABIC;
    end else if (in_rng(c, 21'h01F00, 21'h01FFF) || in_rng(c, 21'h00370, 21'h003FF)) begin
      r.idx = SCR_GREEK;
    end else if (in_rng(c, 21'h00590, 21'h005FF)) begin
      r.idx = SCR_HEBREW;
    end else if (in_rng(c, 21'h00530, 21'h0058F)) begin
      r.idx = SCR_ARMENIAN;
    end else if (in_rng(c, 21'h00400, 21'h0052F)) begin
      r.idx = SCR_CYRILLIC;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // Keep the lower-index candidate unless the other one is strictly larger
  function automatic cand_t pick_max(cand_t a, cand_t b);
    return (b.cnt > a.cnt) ? b : a;
  endfunction

endpackage

// ----- src/ushc_argmax.sv -----
// Comparator tree that finds the leading script count, ties going to the lower index.
module ushc_argmax (
  input  ushc_pkg::count_t counts_i [ushc_pkg::NUM_SCRIPTS],
  output ushc_pkg::cand_t  best_o
);
  import ushc_pkg::*;

  cand_t leaf [NUM_SCRIPTS];
  cand_t lvl1 [NUM_SCRIPTS/2];
  cand_t lvl2_lo;
  cand_t lvl2_hi;
  cand_t lvl3;

  // Tag each count with its script index
  always_comb begin
    for (int i = 0; i < NUM_SCRIPTS; i++) begin
      leaf[i].idx = IDX_W'(i);
      leaf[i].cnt = counts_i[i];
    end
  end

  // Reduce neighbor pairs, keeping lower indices on the left
  always_comb begin
    for (int j = 0; j < NUM_SCRIPTS/2; j++) begin
      lvl1[j] = pick_max(leaf[2*j], leaf[2*j+1]);
    end
  end

  assign lvl2_lo = pick_max(lvl1[0], lvl1[1]);
  assign lvl2_hi = pick_max(lvl1[2], lvl1[3]);
  assign lvl3    = pick_max(lvl2_lo, lvl2_hi);
  assign best_o  = pick_max(lvl3, lvl1[4]);

endmodule

// ----- src/unicode_script_histogram_classifier.sv -----
// Top level of the script histogram classifier: counters, share tests and handshakes.
// A result passes through the input, histogram, leader, product and result registers to the output.
// Throughput: one item per cycle unless out_stall_i holds the pipeline; the counters update as
// items move on, so each item sees the counts left by the item before it without waiting.
// Reset clears all counters, thresholds and pipeline valid flags at once.
`include "assert_macros.svh"

module unicode_script_histogram_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ushc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ushc_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ushc_pkg::CP_W-1:0]         code_point_i,
  input  logic                              start_new_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ushc_pkg::VERDICT_W-1:0]    verdict_o,
  output logic [ushc_pkg::OUT_W-1:0]        best_count_o,
  output logic [ushc_pkg::OUT_W-1:0]        seen_count_o
);
  import ushc_pkg::*;

  // Configuration registers
  logic [THR_REG_W-1:0] thr_first_q;
  logic [THR_REG_W-1:0] thr_last_q;
  logic [THR_W-1:0]     unk_thr_q;
  logic [THR_W-1:0]     thr_arr [NUM_SCRIPTS];

  // Stage enables and valid flags
  logic en0, en1, en2, en3, en4;
  logic v0_q, v1_q, v2_q, v3_q, v4_q;

  // Input stage
  class_t cls0_q;
  logic   start0_q;

  // Histogram state
  count_t           cnt_q [NUM_SCRIPTS];
  count_t           cnt_d [NUM_SCRIPTS];
  count_t           base_cnt [NUM_SCRIPTS];
  count_t           total_q, total_d, total_base;
  logic [SUM_W-1:0] sum_q, sum_d, sum_base;
  logic             sum_inc;
  logic             upd;

  // Leader stage
  cand_t            best;
  cand_t            best2_q;
  count_t           total2_q;
  logic [SUM_W-1:0] sum2_q;

  // Product stage
  logic [PB_W-1:0]  p_best3_q, p_thr3_q, p_unk3_q;
  logic [PS_W-1:0]  p_sum3_q;
  logic             has_best3_q;
  script_idx_t      idx3_q;
  logic [OUT_W-1:0] best3_q, total3_q;

  // Result stage
  logic [VERDICT_W-1:0] verdict_d, verdict_q;
  logic [OUT_W-1:0]     best_count_q, seen_count_q;

  // Advance a stage when it is empty or the stage after it advances
  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_stall_o = !en0;
  assign upd = v0_q && en1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_first_q <= '0;
      thr_last_q  <= '0;
      unk_thr_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THR_FIRST: thr_first_q <= cfg_wdata_i[THR_REG_W-1:0];
        CFG_THR_LAST:  thr_last_q  <= cfg_wdata_i[THR_REG_W-1:0];
        CFG_UNKNOWN:   unk_thr_q   <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack per-script thresholds
  always_comb begin
    for (int i = 0; i < NUM_SCRIPTS; i++) begin
      if (i < THR_PER_REG) begin
        thr_arr[i] = thr_first_q[(i % THR_PER_REG)*THR_W +: THR_W];
      end else begin
        thr_arr[i] = thr_last_q[(i % THR_PER_REG)*THR_W +: THR_W];
      end
    end
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Classify the code point as it is captured
  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      cls0_q   <= classify(code_point_i);
      start0_q <= start_new_i;
    end
  end

  // Clear on start, then bump the total and the hit script, saturating
  always_comb begin
    sum_inc    = 1'b0;
    total_base = start0_q ? '0 : total_q;
    sum_base   = start0_q ? '0 : sum_q;
    total_d    = (total_base != COUNT_MAX) ? total_base + count_t'(1) : total_base;
    for (int i = 0; i < NUM_SCRIPTS; i++) begin
      base_cnt[i] = start0_q ? '0 : cnt_q[i];
      cnt_d[i]    = base_cnt[i];
      if (cls0_q.hit && (cls0_q.idx == IDX_W'(i)) && (base_cnt[i] != COUNT_MAX)) begin
        cnt_d[i] = base_cnt[i] + count_t'(1);
        sum_inc  = 1'b1;
      end
    end
    sum_d = sum_inc ? sum_base + SUM_W'(1) : sum_base;
  end

  // Hold the histogram between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SCRIPTS; i++) cnt_q[i] <= '0;
      total_q <= '0;
      sum_q   <= '0;
    end else if (upd) begin
      for (int i = 0; i < NUM_SCRIPTS; i++) cnt_q[i] <= cnt_d[i];
      total_q <= total_d;
      sum_q   <= sum_d;
    end
  end

  ushc_argmax u_argmax (
    .counts_i (cnt_q),
    .best_o   (best)
  );

  // Capture the leader and a snapshot of the totals
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      best2_q  <= best;
      total2_q <= total_q;
      sum2_q   <= sum_q;
    end
  end

  // Form the cross products of the share tests
  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      p_best3_q   <= PB_W'(best2_q.cnt) * PB_W'(PERCENT_FULL);
      p_thr3_q    <= PB_W'(thr_arr[best2_q.idx]) * PB_W'(total2_q);
      p_sum3_q    <= PS_W'(sum2_q) * PS_W'(PERCENT_FULL);
      p_unk3_q    <= PB_W'(unk_thr_q) * PB_W'(total2_q);
      has_best3_q <= (best2_q.cnt != '0);
      idx3_q      <= best2_q.idx;
      best3_q     <= OUT_W'(best2_q.cnt);
      total3_q    <= OUT_W'(total2_q);
    end
  end

  // Decide the verdict
  always_comb begin
    if (has_best3_q && (p_best3_q > p_thr3_q)) begin
      verdict_d = VERDICT_W'(idx3_q);
    end else if (p_sum3_q > PS_W'(p_unk3_q)) begin
      verdict_d = VERDICT_UNKNOWN;
    end else begin
      verdict_d = VERDICT_NONE;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      verdict_q    <= verdict_d;
      best_count_q <= best3_q;
      seen_count_q <= total3_q;
    end
  end

  assign out_valid_o  = v4_q;
  assign verdict_o    = verdict_q;
  assign best_count_o = best_count_q;
  assign seen_count_o = seen_count_q;

  // Script hits never outrun the item count until the total saturates
  `ASSERT_IMPL(a_sum_le_total, total_q != COUNT_MAX, sum_q <= SUM_W'(total_q))
  // A start item leaves exactly one item counted
  `ASSERT_NEXT(a_start_restarts, upd && start0_q, total_q == count_t'(1))

endmodule
